[hw/rtl/mas_pkg.sv]
// Shared constants and types of the moving average smoother.
package mas_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int MAX_SPAN     = 63;
	localparam int FRAME_W      = 16;
	localparam int SPAN_W       = $clog2(MAX_SPAN + 1);
	localparam int HALF_W       = SPAN_W - 1;
	localparam int STORE_DEPTH  = MAX_SPAN + 1;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int SUM_W        = SAMPLE_WIDTH + SPAN_W;
	localparam int AVG_W        = 24;
	localparam int FRAC_W       = 8;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = FRAME_W;
	localparam int OUT_DATA_W   = AVG_W + FRAME_W;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN         = 1'd1;

	localparam logic [FRAME_W-1:0] FRAME_LENGTH_RST = 16'd1024;
	localparam logic [SPAN_W-1:0]  SPAN_RST         = 6'd5;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [SPAN_W-1:0]       div;
		logic [FRAME_W-1:0]      pos;
		logic                    last;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} push_t;

endpackage

[hw/rtl/mas_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/mas_front.sv]
// Front end: config registers, prefix sums, window classification and tail sequencing.
module mas_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mas_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [mas_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata,
	output mas_pkg::push_t                  push,
	input  logic [mas_pkg::QCNT_W-1:0]      q_count
);
	import mas_pkg::*;

	typedef enum logic {ST_IDLE, ST_TAIL} state_t;
	typedef enum logic [1:0] {MODE_DIRECT, MODE_HEAD, MODE_DIFF} mode_t;

	state_t                  state_q;
	logic [FRAME_W-1:0]      frame_length_q;
	logic [SPAN_W-1:0]       span_q;
	logic [FRAME_W-1:0]      count_q;
	logic signed [SUM_W-1:0] prefix_q;
	logic [HALF_W-1:0]       tail_cnt_q;
	logic [FRAME_W-1:0]      tail_pos_q;
	logic [ADDR_W-1:0]       tail_rd_q;
	logic [SPAN_W-1:0]       tail_div_q;

	logic                    valid_s1;
	mode_t                   mode_s1;
	logic signed [SUM_W-1:0] qhi_s1;
	logic [SPAN_W-1:0]       div_s1;
	logic [FRAME_W-1:0]      pos_s1;
	logic                    last_s1;

	logic [QCNT_W:0]         pend;
	logic                    room;
	logic                    accept;
	logic [SPAN_W-1:0]       sp_eff;
	logic [HALF_W-1:0]       half;
	logic [SPAN_W-1:0]       two_h;
	logic signed [SUM_W-1:0] qk;
	logic [FRAME_W:0]        cnt_inc;
	logic                    is_final;
	logic                    emit_ok;
	logic [FRAME_W-1:0]      i_mid;
	logic [FRAME_W-1:0]      lo_mid;
	logic                    head_region;

	logic                    issue;
	mode_t                   mode;
	logic [ADDR_W-1:0]       rd_addr;
	logic signed [SUM_W-1:0] qhi;
	logic [SPAN_W-1:0]       div;
	logic [FRAME_W-1:0]      pos;
	logic                    last;

	logic [SUM_W-1:0]        rdata;
	logic signed [SUM_W-1:0] rd_sum;
	logic signed [SUM_W-1:0] sum_s1;

	assign pend          = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(valid_s1);
	assign room          = pend < (QCNT_W+1)'(QUEUE_DEPTH);
	assign s_axis_tready = (state_q == ST_IDLE) && room;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign sp_eff      = (span_q == '0) ? SPAN_W'(1) : span_q;
	assign half        = HALF_W'((sp_eff - SPAN_W'(1)) >> 1);
	assign two_h       = {half, 1'b0};
	assign qk          = ((count_q == '0) ? SUM_W'(0) : prefix_q)
		+ SUM_W'($signed(s_axis_tdata));
	assign cnt_inc     = {1'b0, count_q} + (FRAME_W+1)'(1);
	assign is_final    = cnt_inc >= {1'b0, frame_length_q};
	assign emit_ok     = frame_length_q > FRAME_W'(sp_eff);
	assign i_mid       = count_q - FRAME_W'(half);
	assign lo_mid      = count_q - FRAME_W'(two_h);
	assign head_region = count_q < FRAME_W'(two_h);

	always_comb begin
		issue   = 1'b0;
		mode    = MODE_DIFF;
		rd_addr = lo_mid[ADDR_W-1:0] - ADDR_W'(1);
		qhi     = qk;
		div     = sp_eff;
		pos     = i_mid;
		last    = 1'b0;
		if (state_q == ST_TAIL) begin
			issue   = room;
			rd_addr = tail_rd_q;
			qhi     = prefix_q;
			div     = tail_div_q;
			pos     = tail_pos_q;
			last    = (tail_cnt_q == HALF_W'(1));
		end else if (accept && emit_ok) begin
			if (is_final) begin
				issue = 1'b1;
				last  = (half == '0);
			end else if (count_q >= FRAME_W'(half)) begin
				issue = 1'b1;
				if (head_region) begin
					mode    = MODE_HEAD;
					rd_addr = {i_mid[ADDR_W-2:0], 1'b0};
					div     = {i_mid[SPAN_W-2:0], 1'b1};
				end else if (lo_mid == '0) begin
					mode = MODE_DIRECT;
				end
			end
		end
	end

	mas_ram #(
		.WIDTH (SUM_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (qk),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			frame_length_q <= FRAME_LENGTH_RST;
			span_q         <= SPAN_RST;
			count_q        <= '0;
			prefix_q       <= '0;
			tail_cnt_q     <= '0;
			tail_pos_q     <= '0;
			tail_rd_q      <= '0;
			tail_div_q     <= '0;
			valid_s1       <= 1'b0;
			mode_s1        <= MODE_DIRECT;
			qhi_s1         <= '0;
			div_s1         <= '0;
			pos_s1         <= '0;
			last_s1        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_LENGTH: frame_length_q <= cfg_data[FRAME_W-1:0];
					REG_SPAN:         span_q         <= cfg_data[SPAN_W-1:0];
				endcase
			end
			if (cfg_we) begin
				count_q <= '0;
			end else if (accept) begin
				count_q <= is_final ? '0 : cnt_inc[FRAME_W-1:0];
			end
			if (accept) begin
				prefix_q <= qk;
				if (is_final && emit_ok && (half != '0)) begin
					state_q    <= ST_TAIL;
					tail_cnt_q <= half;
					tail_pos_q <= i_mid + FRAME_W'(1);
					tail_rd_q  <= lo_mid[ADDR_W-1:0] + ADDR_W'(1);
					tail_div_q <= two_h - SPAN_W'(1);
				end
			end
			if ((state_q == ST_TAIL) && room) begin
				tail_cnt_q <= tail_cnt_q - HALF_W'(1);
				tail_pos_q <= tail_pos_q + FRAME_W'(1);
				tail_rd_q  <= tail_rd_q + ADDR_W'(2);
				tail_div_q <= tail_div_q - SPAN_W'(2);
				if (tail_cnt_q == HALF_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end
			valid_s1 <= issue;
			mode_s1  <= mode;
			qhi_s1   <= qhi;
			div_s1   <= div;
			pos_s1   <= pos;
			last_s1  <= last;
		end
	end

	assign rd_sum = $signed(rdata);

	always_comb begin
		case (mode_s1)
			MODE_DIRECT: sum_s1 = qhi_s1;
			MODE_HEAD:   sum_s1 = rd_sum;
			default:     sum_s1 = qhi_s1 - rd_sum;
		endcase
	end

	assign push.valid   = valid_s1;
	assign push.op.sum  = sum_s1;
	assign push.op.div  = div_s1;
	assign push.op.pos  = pos_s1;
	assign push.op.last = last_s1;

	a_tail_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL) |-> (tail_cnt_q != '0))
		else $error("tail sequence running with nothing left");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && accept) |-> (rd_addr != count_q[ADDR_W-1:0]))
		else $error("window read hits the entry being written");

endmodule

[hw/rtl/mas_queue.sv]
// Short queue of window sums between front end and divider.
module mas_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mas_pkg::push_t             push,
	input  logic                       pop,
	output mas_pkg::op_t               head,
	output logic                       not_empty,
	output logic [mas_pkg::QCNT_W-1:0] count
);
	import mas_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	op_t               mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push.valid && pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (count_q != QCNT_W'(QUEUE_DEPTH)))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");

endmodule

[hw/rtl/mas_back.sv]
// Back end: reciprocal divide, saturation and output register.
module mas_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mas_pkg::op_t                   head,
	input  logic                           not_empty,
	output logic                           pop,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [mas_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);
	import mas_pkg::*;

	localparam int MAG_W   = SUM_W - 1;
	localparam int NUM_W   = MAG_W + FRAC_W;
	localparam int RECIP_W = NUM_W + 1;
	localparam int PROD_W  = MAG_W + RECIP_W;
	localparam int P2_W    = RECIP_W + SPAN_W;
	localparam int DIV_CNT = 1 << SPAN_W;
	localparam logic [RECIP_W-1:0] RECIP_NUM   = RECIP_W'(1) << NUM_W;
	localparam logic [RECIP_W-1:0] POS_LIMIT   = RECIP_W'((1 << (AVG_W - 1)) - 1);
	localparam logic [RECIP_W-1:0] NEG_LIMIT   = RECIP_W'(1 << (AVG_W - 1));
	localparam logic [AVG_W-1:0]   AVG_POS_MAX = {1'b0, {(AVG_W-1){1'b1}}};
	localparam logic [AVG_W-1:0]   AVG_NEG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

	logic [RECIP_W-1:0] recip_tbl [DIV_CNT];

	for (genvar gd = 0; gd < DIV_CNT; gd++) begin : g_recip
		localparam logic [RECIP_W-1:0] RV = RECIP_NUM / ((gd == 0) ? 1 : gd);
		assign recip_tbl[gd] = RV;
	end

	logic                    adv;
	logic signed [SUM_W-1:0] neg_sum;
	logic [SUM_W-1:0]        abs_sum;

	logic                    v_s1, v_s2, v_s3;
	logic                    neg_s1, neg_s2, neg_s3;
	logic [MAG_W-1:0]        mag_s1, mag_s2, mag_s3;
	logic [RECIP_W-1:0]      recip_s1;
	logic [SPAN_W-1:0]       div_s1, div_s2;
	logic [FRAME_W-1:0]      pos_s1, pos_s2, pos_s3;
	logic                    last_s1, last_s2, last_s3;
	logic [PROD_W-1:0]       prod_s2;
	logic [RECIP_W-1:0]      q0;
	logic [RECIP_W-1:0]      q0_s3;
	logic [P2_W-1:0]         prod2_s3;

	logic [P2_W-1:0]         num;
	logic [RECIP_W-1:0]      quo;
	logic [AVG_W-1:0]        avg;

	logic                    m_valid_q;
	logic [AVG_W-1:0]        avg_q;
	logic [FRAME_W-1:0]      pos_q;
	logic                    last_q;

	assign adv     = !m_valid_q || m_axis_tready;
	assign pop     = adv && not_empty;
	assign neg_sum = -head.sum;
	assign abs_sum = head.sum[SUM_W-1] ? neg_sum : head.sum;
	assign q0      = prod_s2[PROD_W-1 -: RECIP_W];

	assign num = P2_W'({mag_s3, FRAC_W'(0)});
	assign quo = (prod2_s3 <= num) ? (q0_s3 + RECIP_W'(1)) : q0_s3;

	always_comb begin
		if (neg_s3) begin
			avg = (quo > NEG_LIMIT) ? AVG_NEG_MIN : -quo[AVG_W-1:0];
		end else begin
			avg = (quo > POS_LIMIT) ? AVG_POS_MAX : quo[AVG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1      <= pop;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			m_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1   <= head.sum[SUM_W-1];
			mag_s1   <= abs_sum[MAG_W-1:0];
			recip_s1 <= recip_tbl[head.div];
			div_s1   <= head.div;
			pos_s1   <= head.pos;
			last_s1  <= head.last;

			prod_s2  <= PROD_W'(mag_s1) * PROD_W'(recip_s1);
			neg_s2   <= neg_s1;
			mag_s2   <= mag_s1;
			div_s2   <= div_s1;
			pos_s2   <= pos_s1;
			last_s2  <= last_s1;

			prod2_s3 <= P2_W'(q0 + RECIP_W'(1)) * P2_W'(div_s2);
			q0_s3    <= q0;
			neg_s3   <= neg_s2;
			mag_s3   <= mag_s2;
			pos_s3   <= pos_s2;
			last_s3  <= last_s2;

			avg_q    <= avg;
			pos_q    <= pos_s3;
			last_q   <= last_s3;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {pos_q, avg_q};
	assign m_axis_tlast  = last_q;

	a_stage_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv) |=> m_valid_q)
		else $error("divider result lost before output register");

	a_pop_gated: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (adv && not_empty))
		else $error("queue popped while divider stalled");

endmodule

[hw/rtl/moving_average_smoother_unit.sv]
// Top level of the moving average smoother: front end, queue and divider.
// Path: front-end register, queue, divider stages s1 to s3, output register.
// Throughput: one sample and one result per cycle while the output is ready; the final
// sample of a frame releases h+1 results (h = (span-1)/2), one per cycle from the single
// prefix-sum store read port; the input is held off for them and while the queue is full.
// Reset: frame_length 1024, span 5, frame restarts; store contents are not cleared.
module moving_average_smoother_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mas_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mas_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [mas_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata,   // sample
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [mas_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // average, position
	output logic                             m_axis_tlast
);
	import mas_pkg::*;

	push_t             push;
	op_t               head;
	logic              not_empty;
	logic              pop;
	logic [QCNT_W-1:0] q_count;

	mas_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push          (push),
		.q_count       (q_count)
	);

	mas_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.count     (q_count)
	);

	mas_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.not_empty     (not_empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Testbench of the moving average smoother: directed and random frames checked against a predictor.
module testbench;
	import mas_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int MAX_REPORTS    = 60;
	localparam int AVG_HI         = 2 ** (AVG_W - 1) - 1;
	localparam int AVG_LO         = -(2 ** (AVG_W - 1));

	localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_ONE = SAMPLE_WIDTH'(1);
	localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_NEG = '1;

	typedef struct packed {
		logic signed [AVG_W-1:0] average;
		logic [FRAME_W-1:0]      position;
		logic                    last;
	} smoothed_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [SAMPLE_WIDTH-1:0] s_axis_tdata;   // sample
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;   // average, position
	logic                    m_axis_tlast;

	smoothed_t smoothed_q[$];
	smoothed_t want;
	logic signed [SAMPLE_WIDTH-1:0] window_hist [STORE_DEPTH];
	int unsigned sample_idx;
	int unsigned frame_len_q;
	int unsigned span_q;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int err_count = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int config_writes = 0;

	moving_average_smoother_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic smoothed_t smooth_at(input int unsigned i, input int unsigned sp,
			input int unsigned h);
		int unsigned lo, hi, dv, r;
		int acc, q;
		smoothed_t res;
		if (i < h) begin
			lo = 0;
			hi = 2 * i;
			dv = 2 * i + 1;
		end else if (frame_len_q - i > h) begin
			lo = i - h;
			hi = i + h;
			dv = sp;
		end else begin
			r  = frame_len_q - 1 - i;
			lo = i - r;
			hi = frame_len_q - 1;
			dv = 2 * r + 1;
		end
		acc = 0;
		for (int unsigned j = lo; j <= hi; j++)
			acc += window_hist[j % STORE_DEPTH];
		q = (acc * 256) / int'(dv);
		if (q > AVG_HI)
			q = AVG_HI;
		if (q < AVG_LO)
			q = AVG_LO;
		res.average  = q[AVG_W-1:0];
		res.position = i[FRAME_W-1:0];
		res.last     = (i == frame_len_q - 1);
		return res;
	endfunction

	task automatic absorb_sample(input logic signed [SAMPLE_WIDTH-1:0] x);
		int unsigned k, sp, h;
		bit at_end;
		k = sample_idx;
		window_hist[k % STORE_DEPTH] = x;
		sp = (span_q == 0) ? 1 : span_q;
		if (sp > MAX_SPAN)
			sp = MAX_SPAN;
		h = (sp - 1) / 2;
		at_end = (k + 1 >= frame_len_q);
		if (frame_len_q > sp) begin
			if (at_end) begin
				for (int unsigned i = k - h; i <= k; i++)
					smoothed_q.push_back(smooth_at(i, sp, h));
			end else if (k >= h) begin
				smoothed_q.push_back(smooth_at(k - h, sp, h));
			end
		end
		sample_idx = at_end ? 0 : k + 1;
	endtask

	// valid stays high between back-to-back items; it drops only for idle cycles and in settle
	task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] x);
		if (send_idle_pct > 0) begin
			while ($urandom_range(0, 99) < send_idle_pct) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		absorb_sample(x);
		samples_sent++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (smoothed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input bit wr_len, input bit wr_span, input int unsigned len,
			input int unsigned sp);
		logic [CFG_DATA_W-1:0] word;
		if (wr_len) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_FRAME_LENGTH;
			cfg_data  <= len[FRAME_W-1:0];
			@(posedge clk);
			frame_len_q = len[FRAME_W-1:0];
			sample_idx  = 0;
			config_writes++;
		end
		if (wr_span) begin
			// upper data bits are don't-care for span
			word = CFG_DATA_W'($urandom);
			word[SPAN_W-1:0] = sp[SPAN_W-1:0];
			cfg_we    <= 1'b1;
			cfg_index <= REG_SPAN;
			cfg_data  <= word;
			@(posedge clk);
			span_q     = sp[SPAN_W-1:0];
			sample_idx = 0;
			config_writes++;
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_WIDTH'($urandom_range(0, 8)) - SAMPLE_WIDTH'(4);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string field, input longint exp_v, input longint got_v);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t: %s mismatch at position %0d: expected %0d, got %0d",
				$time, field, want.position, exp_v, got_v);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (smoothed_q.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: unexpected item: expected none, got tdata=%h tlast=%b",
						$time, m_axis_tdata, m_axis_tlast);
			end else begin
				want = smoothed_q.pop_front();
				results_checked++;
				if ($signed(m_axis_tdata[AVG_W-1:0]) !== want.average)
					report_mismatch("average", want.average, $signed(m_axis_tdata[AVG_W-1:0]));
				if (m_axis_tdata[AVG_W +: FRAME_W] !== want.position)
					report_mismatch("position", want.position, m_axis_tdata[AVG_W +: FRAME_W]);
				if (m_axis_tlast !== want.last)
					report_mismatch("last", want.last, m_axis_tlast);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// reset values: length 1024, span 5, full-scale samples mid-frame
	task automatic test_reset_values();
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample('0);
		send_sample(SAMPLE_NEG);
	endtask

	// span zero acts as one, even span, truncation toward zero
	task automatic test_narrow_spans();
		settle();
		write_config(1'b1, 1'b1, 2, 0);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		settle();
		write_config(1'b1, 1'b1, 3, 2);
		send_sample(SAMPLE_ONE);
		send_sample(SAMPLE_NEG);
		send_sample(SAMPLE_MIN);
		settle();
		write_config(1'b1, 1'b1, 4, 3);
		send_sample(SAMPLE_ONE);
		send_sample('0);
		send_sample('0);
		send_sample(SAMPLE_NEG);
	endtask

	// zero length and length equal to span give no output
	task automatic test_empty_frames();
		settle();
		write_config(1'b1, 1'b1, 0, 5);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		settle();
		write_config(1'b1, 1'b0, 5, 5);
		repeat (5) send_sample(rand_sample());
	endtask

	task automatic test_random_frames();
		int unsigned len, sp, n, sent, mode, pick;
		bit wr_len, wr_span;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 49; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 49; end
				default: begin send_idle_pct = 31; stall_pct = 31; end
			endcase
			sent = 0;
			for (int f = 0; sent < 75; f++) begin
				pick = $urandom_range(0, 19);
				mode = $urandom_range(0, 9);
				if (pick == 0)
					sp = 0;
				else if (pick == 1)
					sp = $urandom_range(30, MAX_SPAN);
				else
					sp = $urandom_range(1, 12);
				if (pick == 2)
					len = $urandom_range(0, (sp < 8) ? sp : 8);
				else if (pick == 3)
					len = 1;
				else if (pick == 1)
					len = sp + $urandom_range(1, 4);
				else
					len = sp + $urandom_range(1, 11);
				wr_len  = ($urandom_range(0, 4) != 0) || (frame_len_q > 200);
				wr_span = ($urandom_range(0, 4) != 0) || !wr_len;
				if (f == 0 && ph == 0) begin
					sp = MAX_SPAN;
					len = MAX_SPAN + 1 + $urandom_range(0, 5);
					mode = 5;
				end else if (f == 0 && ph == 1) begin
					sp = $urandom_range(3, 9);
					len = 2 ** FRAME_W - 1;
					mode = 0;
				end else if (f == 0 && ph == 2) begin
					sp = 1;
				end
				if (f == 0) begin
					wr_len = 1'b1;
					wr_span = 1'b1;
				end
				if (!wr_len)
					len = frame_len_q;
				if (!wr_span)
					sp = span_q;
				settle();
				write_config(wr_len, wr_span, len, sp);
				n = (len == 0) ? 3 : len;
				if (mode == 0)
					n = (len > 200) ? 30 : $urandom_range(1, n);
				else if (mode <= 2)
					n = 2 * n;
				repeat (n) begin
					send_sample(rand_sample());
					sent++;
				end
			end
		end
		settle();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		frame_len_q   = FRAME_LENGTH_RST;
		span_q        = SPAN_RST;
		sample_idx    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_narrow_spans();
		test_empty_frames();
		test_random_frames();
		repeat (20) @(posedge clk);
		$display("Sent %0d samples over %0d register writes; checked %0d smoothed items.",
			samples_sent, config_writes, results_checked);
		$display("Spans 0 to %0d, frame lengths 0 to %0d, with idle and stall phases.",
			MAX_SPAN, 2 ** FRAME_W - 1);
		if (err_count == 0 && smoothed_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[moving_average_smoother_unit.f]
hw/rtl/mas_pkg.sv
hw/rtl/mas_ram.sv
hw/rtl/mas_front.sv
hw/rtl/mas_queue.sv
hw/rtl/mas_back.sv
hw/rtl/moving_average_smoother_unit.sv
tb/testbench.sv
